FILE: hdl/min_tracking_stack_macros.svh
// ---------------------------------------------------------------------------
// min_tracking_stack_macros.svh
// Assertion macros used by the min tracking stack checker.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the min tracking stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;

    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 8;
    localparam int RES_W       = 3 * DATA_W + 3 + CNT_W;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W       = M_TDATA_W - RES_W;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic exec;   // item accepted: update counts, write, start reads
        logic load;   // read data back: refresh top caches, load result
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]         fill_count;
        logic                     overflow;
        logic                     underflow;
        logic                     is_empty;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] popped_value;
    } t_result;

endpackage

FILE: hdl/mts_ctrl.sv
// ---------------------------------------------------------------------------
// mts_ctrl
// Two-state controller: accepts an item, then loads its result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mts_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // the result slot is free by the time the next result is loaded
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.exec = w_accept;
    assign o_cmd.load = (r_state == ST_LOAD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (r_state == ST_LOAD)         n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/mts_dp.sv
// ---------------------------------------------------------------------------
// mts_dp
// Datapath: word and minima memories, counts, cached tops, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mts_pkg::t_cmd                          i_cmd,
    input  logic [mts_pkg::MODE_W-1:0]             i_mode,
    input  logic signed [mts_pkg::DATA_W-1:0]      i_value,
    output mts_pkg::t_result                       o_result
);

    logic [mts_pkg::DATA_W-1:0] r_word_mem [mts_pkg::STACK_DEPTH];
    logic [mts_pkg::DATA_W-1:0] r_min_mem  [mts_pkg::STACK_DEPTH];

    logic [mts_pkg::CNT_W-1:0]         r_wcnt, r_mcnt;
    logic signed [mts_pkg::DATA_W-1:0] r_top, r_min;      // cached top entries
    logic [mts_pkg::DATA_W-1:0]        r_word_rd, r_min_rd;
    logic signed [mts_pkg::DATA_W-1:0] r_popped;
    logic                              r_pop_ok, r_min_pop, r_under, r_over;
    mts_pkg::t_result                  r_result;

    logic                              w_push, w_pop, w_full;
    logic                              w_push_ok, w_min_push, w_pop_ok, w_min_pop;
    logic [mts_pkg::CNT_W-1:0]         w_wcnt_m2, w_mcnt_m2;
    logic signed [mts_pkg::DATA_W-1:0] w_top_new, w_min_new;

    assign w_push = (i_mode == mts_pkg::MODE_PUSH);
    assign w_pop  = (i_mode == mts_pkg::MODE_POP);
    assign w_full = (r_wcnt == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));

    assign w_push_ok  = w_push && !w_full;
    assign w_min_push = w_push_ok
                     && (r_mcnt != mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH))
                     && ((r_mcnt == '0) || (i_value <= r_min));
    assign w_pop_ok   = w_pop && (r_wcnt != '0);
    assign w_min_pop  = w_pop_ok && (r_mcnt != '0) && (r_min == r_top);

    // entries that become the new tops after a pop
    assign w_wcnt_m2 = r_wcnt - mts_pkg::CNT_W'(2);
    assign w_mcnt_m2 = r_mcnt - mts_pkg::CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push_ok)
            r_word_mem[r_wcnt[mts_pkg::ADDR_W-1:0]] <= i_value;
        if (i_cmd.exec && w_min_push)
            r_min_mem[r_mcnt[mts_pkg::ADDR_W-1:0]] <= i_value;
        if (i_cmd.exec) begin
            r_word_rd <= r_word_mem[w_wcnt_m2[mts_pkg::ADDR_W-1:0]];
            r_min_rd  <= r_min_mem[w_mcnt_m2[mts_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.exec) begin
            if (w_push_ok)  r_wcnt <= r_wcnt + mts_pkg::CNT_W'(1);
            if (w_pop_ok)   r_wcnt <= r_wcnt - mts_pkg::CNT_W'(1);
            if (w_min_push) r_mcnt <= r_mcnt + mts_pkg::CNT_W'(1);
            if (w_min_pop)  r_mcnt <= r_mcnt - mts_pkg::CNT_W'(1);
        end
    end

    assign w_top_new = r_pop_ok  ? $signed(r_word_rd) : r_top;
    assign w_min_new = r_min_pop ? $signed(r_min_rd)  : r_min;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_push_ok)  r_top <= i_value;
            if (w_min_push) r_min <= i_value;
            r_popped  <= w_pop_ok ? r_top : '0;
            r_pop_ok  <= w_pop_ok;
            r_min_pop <= w_min_pop;
            r_under   <= w_pop && (r_wcnt == '0);
            r_over    <= w_push && w_full;
        end
        if (i_cmd.load) begin
            r_top <= w_top_new;
            r_min <= w_min_new;
            r_result.popped_value <= r_popped;
            r_result.top_value    <= (r_wcnt == '0) ? '0 : w_top_new;
            r_result.min_value    <= ((r_wcnt == '0) || (r_mcnt == '0)) ? '0 : w_min_new;
            r_result.is_empty     <= (r_wcnt == '0);
            r_result.underflow    <= r_under;
            r_result.overflow     <= r_over;
            r_result.fill_count   <= r_wcnt;
        end
    end

    assign o_result = r_result;

endmodule

FILE: hdl/min_tracking_stack.sv
// ---------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that reports its running minimum.
// ---------------------------------------------------------------------------
// Channel   Dir  Item
// s_axis    in   tuser[1:0] mode, tdata[31:0] value
// m_axis    out  popped, top, min, is_empty, underflow, overflow, fill_count
//
// On accept the block updates counts, writes the memories and issues the reads of
// the entries below the tops; the load state then brings back the read data.
// No new item is taken while one is in flight or while the output is stalled.
// Reset clears both counts; memory contents are left as they are.
// A stalled result holds in the output register; input waits until it can go.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mts_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] value
    input  logic [mts_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // [1:0] mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value, [96] is_empty,
    // [97] underflow, [98] overflow, [107:99] fill_count, rest zero
    output logic [mts_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    mts_pkg::t_cmd    w_cmd;
    mts_pkg::t_result w_result;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    mts_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mode   (s_axis_tuser[mts_pkg::MODE_W-1:0]),
        .i_value  ($signed(s_axis_tdata[mts_pkg::DATA_W-1:0])),
        .o_result (w_result)
    );

    assign m_axis_tdata = {{mts_pkg::PAD_W{1'b0}}, w_result};

endmodule

FILE: hdl/mts_checker.sv
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks for the min tracking stack, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_macros.svh"

module mts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);

    logic w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    `MTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `MTS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_acc, !s_axis_tready, "item taken while one is in flight")
    `MTS_ASSERT_IMPL(a_result_due, i_clk, i_rst_n, w_in_acc, ##2 m_axis_tvalid, "result missing two cycles after accept")
    `MTS_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[96], m_axis_tdata[95:32] == 64'd0, "empty stack reports nonzero top or min")
    `MTS_ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[107:99] <= 9'd256 && !(m_axis_tdata[97] && m_axis_tdata[98]), "fill count or flags out of range")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
